// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, pre, post, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- src/dtwt_pkg.sv -----
// ---------------------------------------------------------------------------
// dtwt_pkg
// Types and constants of the dirty tile window tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package dtwt_pkg;

  localparam int GRID_DEF  = 8;
  localparam int MAX_TILES = 64;
  localparam int CMDQ_DEPTH = 4;

  localparam int CRD_W  = 10;  // pixel coordinate / panel size
  localparam int TIDX_W = 6;   // tile index
  localparam int TCRD_W = 3;   // tile column / row

  // request function codes
  localparam logic [1:0] FUNC_PIXEL    = 2'd0;
  localparam logic [1:0] FUNC_FLUSH    = 2'd1;
  localparam logic [1:0] FUNC_MARK_ALL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NATIVE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_NATIVE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LANDSCAPE     = 2'd2;

  localparam logic [CRD_W-1:0] NATIVE_WIDTH_RST  = 10'd240;
  localparam logic [CRD_W-1:0] NATIVE_HEIGHT_RST = 10'd320;

  typedef struct packed {
    logic [1:0]       func;
    logic [CRD_W-1:0] pixel_x;
    logic [CRD_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [TIDX_W-1:0] tile_index;
    logic [CRD_W-1:0]  x_start;
    logic [CRD_W-1:0]  x_end;
    logic [CRD_W-1:0]  y_start;
    logic [CRD_W-1:0]  y_end;
    logic              last;
  } out_item_t;

  // effective frame and tile sizes, plus the mark-all pulse of a config write
  typedef struct packed {
    logic [CRD_W-1:0] w_eff;
    logic [CRD_W-1:0] h_eff;
    logic [CRD_W-1:0] tw;
    logic [CRD_W-1:0] th;
    logic             mark_all;
  } geom_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIDX_W-1:0] tile;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/dtwt_geom.sv -----
// ---------------------------------------------------------------------------
// dtwt_geom
// Configuration registers and derived tile sizes (effective size / GRID).
// ---------------------------------------------------------------------------
`default_nettype none

module dtwt_geom #(
  parameter int GRID = dtwt_pkg::GRID_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [dtwt_pkg::CRD_W-1:0]  cfg_wdata,
  output dtwt_pkg::geom_t                  geom
);

  // floor(v / GRID) = (v * RECIP) >> SHIFT, exact for 10-bit v and GRID <= 8
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SHIFT) + GRID - 1) / GRID);
  localparam int PROD_W = dtwt_pkg::CRD_W + RECIP_W;

  logic [dtwt_pkg::CRD_W-1:0] nat_w_r, nat_w_nxt;
  logic [dtwt_pkg::CRD_W-1:0] nat_h_r, nat_h_nxt;
  logic                       land_r, land_nxt;
  logic [dtwt_pkg::CRD_W-1:0] w_eff_r, h_eff_r, tw_r, th_r;
  logic [dtwt_pkg::CRD_W-1:0] w_eff_nxt, h_eff_nxt;
  logic [PROD_W-1:0]          prod_w, prod_h;
  logic                       reg_hit;

  always_comb begin
    nat_w_nxt = nat_w_r;
    nat_h_nxt = nat_h_r;
    land_nxt  = land_r;
    reg_hit   = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        dtwt_pkg::REG_NATIVE_WIDTH: begin
          nat_w_nxt = cfg_wdata;
          reg_hit   = 1'b1;
        end
        dtwt_pkg::REG_NATIVE_HEIGHT: begin
          nat_h_nxt = cfg_wdata;
          reg_hit   = 1'b1;
        end
        dtwt_pkg::REG_LANDSCAPE: begin
          land_nxt = cfg_wdata[0];
          reg_hit  = 1'b1;
        end
        default: ;
      endcase
    end
    w_eff_nxt = land_nxt ? nat_h_nxt : nat_w_nxt;
    h_eff_nxt = land_nxt ? nat_w_nxt : nat_h_nxt;
    prod_w    = PROD_W'(w_eff_nxt) * PROD_W'(RECIP);
    prod_h    = PROD_W'(h_eff_nxt) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nat_w_r <= dtwt_pkg::NATIVE_WIDTH_RST;
      nat_h_r <= dtwt_pkg::NATIVE_HEIGHT_RST;
      land_r  <= 1'b0;
      w_eff_r <= dtwt_pkg::NATIVE_WIDTH_RST;
      h_eff_r <= dtwt_pkg::NATIVE_HEIGHT_RST;
      tw_r    <= dtwt_pkg::CRD_W'(int'(dtwt_pkg::NATIVE_WIDTH_RST) / GRID);
      th_r    <= dtwt_pkg::CRD_W'(int'(dtwt_pkg::NATIVE_HEIGHT_RST) / GRID);
    end else begin
      nat_w_r <= nat_w_nxt;
      nat_h_r <= nat_h_nxt;
      land_r  <= land_nxt;
      w_eff_r <= w_eff_nxt;
      h_eff_r <= h_eff_nxt;
      tw_r    <= prod_w[RECIP_SHIFT +: dtwt_pkg::CRD_W];
      th_r    <= prod_h[RECIP_SHIFT +: dtwt_pkg::CRD_W];
    end
  end

  assign geom.w_eff    = w_eff_r;
  assign geom.h_eff    = h_eff_r;
  assign geom.tw       = tw_r;
  assign geom.th       = th_r;
  assign geom.mark_all = reg_hit;

endmodule

`default_nettype wire

// ----- src/dtwt_front.sv -----
// ---------------------------------------------------------------------------
// dtwt_front
// Takes requests, drops the ones with no effect, maps a pixel to its tile
// by stepping tile boundaries, and queues a command for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module dtwt_front #(
  parameter int GRID = dtwt_pkg::GRID_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  dtwt_pkg::in_item_t      in_data,
  input  dtwt_pkg::geom_t         geom,
  output logic                    q_push,
  output dtwt_pkg::cmd_t          q_wr,
  input  wire logic               q_full
);

  localparam int BND_W = dtwt_pkg::CRD_W + 1;
  localparam logic [dtwt_pkg::TCRD_W-1:0] LAST_COL = dtwt_pkg::TCRD_W'(GRID - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                        state_r, state_nxt;
  logic [1:0]                     op_r, op_nxt;
  logic [dtwt_pkg::CRD_W-1:0]     px_r, px_nxt, py_r, py_nxt;
  logic [dtwt_pkg::TCRD_W-1:0]    col_r, col_nxt, row_r, row_nxt;
  logic [BND_W-1:0]               bx_r, bx_nxt, by_r, by_nxt;
  logic                           accept, x_go, y_go, in_frame;
  logic [dtwt_pkg::TIDX_W-1:0]    tile_idx;

  assign in_full  = (state_r != F_IDLE);
  assign accept   = in_push && !in_full;
  assign in_frame = (in_data.pixel_x < geom.w_eff) && (in_data.pixel_y < geom.h_eff);
  // boundary k*tw passed means column k or beyond; a zero tile size saturates
  assign x_go     = (col_r != LAST_COL) && (BND_W'(px_r) >= bx_r);
  assign y_go     = (row_r != LAST_COL) && (BND_W'(py_r) >= by_r);
  assign tile_idx = dtwt_pkg::TIDX_W'(col_r)
                  + dtwt_pkg::TIDX_W'(row_r) * dtwt_pkg::TIDX_W'(GRID);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    q_push    = 1'b0;
    q_wr.op   = op_r;
    q_wr.tile = tile_idx;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          op_nxt  = in_data.func;
          px_nxt  = in_data.pixel_x;
          py_nxt  = in_data.pixel_y;
          col_nxt = '0;
          row_nxt = '0;
          bx_nxt  = BND_W'(geom.tw);
          by_nxt  = BND_W'(geom.th);
          case (in_data.func)
            dtwt_pkg::FUNC_PIXEL: begin
              if (in_frame) state_nxt = F_DIV;
            end
            dtwt_pkg::FUNC_FLUSH,
            dtwt_pkg::FUNC_MARK_ALL: state_nxt = F_PUSH;
            default: ;
          endcase
        end
      end
      F_DIV: begin
        if (x_go) begin
          col_nxt = col_r + 1'b1;
          bx_nxt  = bx_r + BND_W'(geom.tw);
        end
        if (y_go) begin
          row_nxt = row_r + 1'b1;
          by_nxt  = by_r + BND_W'(geom.th);
        end
        if (!x_go && !y_go && !q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    col_r <= col_nxt;
    row_r <= row_nxt;
    bx_r  <= bx_nxt;
    by_r  <= by_nxt;
  end

endmodule

`default_nettype wire

// ----- src/dtwt_cmdq.sv -----
// ---------------------------------------------------------------------------
// dtwt_cmdq
// Small command queue between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module dtwt_cmdq #(
  parameter int DEPTH = dtwt_pkg::CMDQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  dtwt_pkg::cmd_t   wr,
  output logic             full,
  input  wire logic        pop,
  output dtwt_pkg::cmd_t   rd,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dtwt_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr;
  end

endmodule

`default_nettype wire

// ----- src/dtwt_back.sv -----
// ---------------------------------------------------------------------------
// dtwt_back
// Owns the dirty bits; runs queued commands and the flush scan, and holds
// the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dtwt_back #(
  parameter int GRID = dtwt_pkg::GRID_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  dtwt_pkg::geom_t         geom,
  input  dtwt_pkg::cmd_t          q_rd,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output dtwt_pkg::out_item_t     out_data
);

  localparam logic [dtwt_pkg::TIDX_W-1:0] LAST_TILE = dtwt_pkg::TIDX_W'(GRID * GRID - 1);
  localparam logic [dtwt_pkg::TCRD_W-1:0] LAST_COL  = dtwt_pkg::TCRD_W'(GRID - 1);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_TAIL = 3'b100
  } bstate_t;

  bstate_t                          state_r, state_nxt;
  logic [dtwt_pkg::MAX_TILES-1:0]   dirty_r, dirty_nxt;
  logic [dtwt_pkg::TIDX_W-1:0]      scan_r, scan_nxt;
  logic [dtwt_pkg::TCRD_W-1:0]      col_r, col_nxt, row_r, row_nxt;
  dtwt_pkg::out_item_t              pend_r, pend_nxt, out_r, out_nxt, win;
  logic                             has_pend_r, has_pend_nxt;
  logic                             out_vld_r, out_vld_nxt;
  logic                             out_take, out_free, hit, stall;
  logic [dtwt_pkg::CRD_W-1:0]       xs, ys;

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;
  assign out_take  = out_pop && out_vld_r;
  assign out_free  = !out_vld_r || out_take;

  assign xs = dtwt_pkg::CRD_W'(dtwt_pkg::CRD_W'(col_r) * geom.tw);
  assign ys = dtwt_pkg::CRD_W'(dtwt_pkg::CRD_W'(row_r) * geom.th);

  always_comb begin
    win.tile_index = scan_r;
    win.x_start    = xs;
    win.x_end      = xs + geom.tw - 1'b1;
    win.y_start    = ys;
    win.y_end      = ys + geom.th - 1'b1;
    win.last       = 1'b0;
  end

  assign hit   = dirty_r[scan_r];
  // the held window can only move on once the result register frees up
  assign stall = hit && has_pend_r && !out_free;

  always_comb begin
    state_nxt    = state_r;
    dirty_nxt    = dirty_r;
    scan_nxt     = scan_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pend_nxt     = pend_r;
    has_pend_nxt = has_pend_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_take;
    q_pop        = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_rd.op)
            dtwt_pkg::FUNC_PIXEL:    dirty_nxt[q_rd.tile] = 1'b1;
            dtwt_pkg::FUNC_MARK_ALL: dirty_nxt = '1;
            dtwt_pkg::FUNC_FLUSH: begin
              scan_nxt     = '0;
              col_nxt      = '0;
              row_nxt      = '0;
              has_pend_nxt = 1'b0;
              state_nxt    = B_SCAN;
            end
            default: ;
          endcase
        end
      end
      B_SCAN: begin
        if (!stall) begin
          if (hit) begin
            dirty_nxt[scan_r] = 1'b0;
            if (has_pend_r) begin
              out_nxt     = pend_r;
              out_vld_nxt = 1'b1;
            end
            pend_nxt     = win;
            has_pend_nxt = 1'b1;
          end
          if (scan_r == LAST_TILE) begin
            state_nxt = B_TAIL;
          end else begin
            scan_nxt = scan_r + 1'b1;
            if (col_r == LAST_COL) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      B_TAIL: begin
        if (!has_pend_r) begin
          state_nxt = B_IDLE;
        end else if (out_free) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          out_vld_nxt  = 1'b1;
          has_pend_nxt = 1'b0;
          state_nxt    = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    // geometry changed: every tile needs a redraw
    if (geom.mark_all) dirty_nxt = '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      dirty_r    <= '1;
      has_pend_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dirty_r    <= dirty_nxt;
      has_pend_r <= has_pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- src/dirty_tile_window_tracker_unit.sv -----
// ---------------------------------------------------------------------------
// dirty_tile_window_tracker_unit
// Tracks a dirty bit per display tile and flushes dirty tile windows.
// ---------------------------------------------------------------------------
//  channel  ports                          request
//  in       in_push / in_full / in_data    func, pixel_x, pixel_y
//  out      out_pop / out_empty / out_data one tile window, last on the final
//  cfg      cfg_we / cfg_index / cfg_wdata native_width, native_height, landscape
//
//  Pixel write: the front end takes it, steps tile boundaries (one step per
//  cycle) and queues a command; the back end pops it and sets the dirty bit.
//  Off-frame pixels and the unused func code are dropped in the accept cycle.
//  Mark-all and flush are queued as is; for a flush the back end pops it,
//  scans one tile per cycle while not stalled, then sends the final window.
//  The scan holds while a found window waits on out_pop; the front end keeps
//  taking requests until the command queue fills.
//  Reset (rst_n low, synchronous) marks every tile dirty; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dirty_tile_window_tracker_unit #(
  parameter int GRID = dtwt_pkg::GRID_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  dtwt_pkg::in_item_t               in_data,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output dtwt_pkg::out_item_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [dtwt_pkg::CRD_W-1:0]  cfg_wdata
);

  localparam logic [dtwt_pkg::TIDX_W-1:0] TILE_LAST = dtwt_pkg::TIDX_W'(GRID * GRID - 1);
  localparam logic [1:0] OP_PIXEL = dtwt_pkg::FUNC_PIXEL;

  dtwt_pkg::geom_t  geom;
  dtwt_pkg::cmd_t   q_wr, q_rd;
  logic             q_push, q_full, q_pop, q_empty;

  dtwt_geom #(.GRID(GRID)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  dtwt_front #(.GRID(GRID)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .geom    (geom),
    .q_push  (q_push),
    .q_wr    (q_wr),
    .q_full  (q_full)
  );

  dtwt_cmdq #(.DEPTH(dtwt_pkg::CMDQ_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .rd    (q_rd),
    .empty (q_empty)
  );

  dtwt_back #(.GRID(GRID)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .q_rd      (q_rd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  `ASSERT_NEVER(a_q_overflow, q_push && q_full, "command pushed into full queue")
  `ASSERT_NEVER(a_q_underflow, q_pop && q_empty, "command popped from empty queue")
  `ASSERT_IMPLY(a_pix_tile, q_push && q_wr.op == OP_PIXEL, q_wr.tile <= TILE_LAST, "tile past grid")
  `ASSERT_IMPLY(a_out_tile, !out_empty, out_data.tile_index <= TILE_LAST, "window past grid")

endmodule

`default_nettype wire
